// ----- hw/rtl/clx_pkg.sv -----
// Shared types, codes and character classes for the command line lexer.
`default_nettype none
package clx_pkg;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_DASH  = 3'd1,
    ST_WORD  = 3'd2,
    ST_QUOTE = 3'd3,
    ST_SEP   = 3'd4,
    ST_NEG   = 3'd5,
    ST_PNAME = 3'd6,
    ST_DONE  = 3'd7
  } lex_state_t;

  localparam logic ITEM_CHAR = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  localparam logic [1:0] TOK_NONE  = 2'd0;
  localparam logic [1:0] TOK_VALUE = 2'd1;
  localparam logic [1:0] TOK_PNAME = 2'd2;
  localparam logic [1:0] TOK_SEP   = 2'd3;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       item_kind;
    logic [7:0] char_out;
    logic [1:0] token_kind;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic       emit;
    res_item_t  item;
    lex_state_t nxt;
  } idle_res_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_SLASH || c == CH_DOT || c == CH_UNDER;
  endfunction

  function automatic res_item_t char_item(input logic [7:0] c);
    res_item_t r;
    r.item_kind  = ITEM_CHAR;
    r.char_out   = c;
    r.token_kind = TOK_NONE;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic res_item_t end_item(input logic [1:0] tok);
    res_item_t r;
    r.item_kind  = ITEM_END;
    r.char_out   = 8'd0;
    r.token_kind = tok;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic idle_res_t idle_step(input logic [7:0] c);
    idle_res_t r;
    r.emit = 1'b0;
    r.item = char_item(c);
    r.nxt  = ST_IDLE;
    if (is_word(c)) begin
      r.emit = 1'b1;
      r.nxt  = ST_WORD;
    end else if (c == CH_DASH) begin
      r.nxt = ST_DASH;
    end else if (c == CH_TILDE) begin
      r.nxt = ST_SEP;
    end else if (c == CH_QUOTE) begin
      r.nxt = ST_QUOTE;
    end else if (c == CH_HASH) begin
      r.emit = 1'b1;
      r.item = end_item(TOK_NONE);
      r.nxt  = ST_DONE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/clx_if.sv -----
// Request channel interfaces for lexer input bytes and lexer results.
`default_nettype none
interface clx_in_if;
  import clx_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_start;
  modport source (output valid, output char_code, output line_start, input ready);
  modport sink (input valid, input char_code, input line_start, output ready);
endinterface

interface clx_out_if;
  import clx_pkg::*;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] char_out;
  logic [1:0] token_kind;
  logic       last;
  modport source (output valid, output item_kind, output char_out, output token_kind,
                  output last, input ready);
  modport sink (input valid, input item_kind, input char_out, input token_kind,
                input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/clx_step.sv -----
// Lexer step logic: one byte and the current state give up to two results.
`default_nettype none
module clx_step (
  input  clx_pkg::lex_state_t state,
  input  logic [7:0]          char_code,
  input  logic                line_start,
  output clx_pkg::lex_state_t state_nxt,
  output logic [1:0]          res_cnt,
  output clx_pkg::res_item_t  res0,
  output clx_pkg::res_item_t  res1
);
  import clx_pkg::*;

  lex_state_t cur;
  idle_res_t  idle_r;
  logic       redo;
  logic [1:0] n1;
  res_item_t  a0;
  res_item_t  a1;
  lex_state_t s1;

  assign cur    = line_start ? ST_IDLE : state;
  assign idle_r = idle_step(char_code);

  always_comb begin
    redo = 1'b0;
    n1   = 2'd0;
    a0   = char_item(char_code);
    a1   = char_item(char_code);
    s1   = cur;
    unique case (cur)
      ST_IDLE: begin
        n1 = {1'b0, idle_r.emit};
        a0 = idle_r.item;
        s1 = idle_r.nxt;
      end
      ST_DASH: begin
        if (is_alpha(char_code)) begin
          n1 = 2'd1;
          s1 = ST_PNAME;
        end else if (is_digit(char_code)) begin
          n1 = 2'd2;
          a0 = char_item(CH_DASH);
          s1 = ST_NEG;
        end else begin
          n1   = 2'd1;
          a0   = end_item(TOK_NONE);
          redo = 1'b1;
        end
      end
      ST_WORD: begin
        n1 = 2'd1;
        if (!is_word(char_code)) begin
          a0   = end_item(TOK_VALUE);
          redo = 1'b1;
        end
      end
      ST_QUOTE: begin
        n1 = 2'd1;
        if (char_code == CH_QUOTE) begin
          a0 = end_item(TOK_VALUE);
          s1 = ST_IDLE;
        end
      end
      ST_SEP: begin
        if (char_code != CH_TILDE && char_code != CH_COLON) begin
          n1   = 2'd1;
          a0   = end_item(TOK_SEP);
          redo = 1'b1;
        end
      end
      ST_NEG: begin
        n1 = 2'd1;
        if (!is_digit(char_code)) begin
          a0   = end_item(TOK_VALUE);
          redo = 1'b1;
        end
      end
      ST_PNAME: begin
        n1 = 2'd1;
        if (!(is_alpha(char_code) || is_digit(char_code))) begin
          a0   = end_item(TOK_PNAME);
          redo = 1'b1;
        end
      end
      ST_DONE: begin
        n1 = 2'd0;
      end
      default: begin
        n1 = 2'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt = s1;
    res_cnt   = n1;
    res0      = a0;
    res1      = a1;
    if (redo) begin
      state_nxt = idle_r.nxt;
      res1      = idle_r.item;
      res_cnt   = idle_r.emit ? 2'd2 : 2'd1;
    end
    res0.last = (res_cnt == 2'd1);
    res1.last = 1'b1;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/clx_queue.sv -----
// Result queue: takes up to two results per cycle, delivers one per cycle while out_ready is high.
`default_nettype none
module clx_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  clx_pkg::res_item_t push0,
  input  clx_pkg::res_item_t push1,
  output logic               room2,
  output logic               out_valid,
  input  logic               out_ready,
  output clx_pkg::res_item_t out_item
);
  import clx_pkg::*;

  res_item_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_nxt;
  logic [QUEUE_AW:0]     cnt_r;
  logic [QUEUE_AW:0]     cnt_nxt;
  logic                  pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign room2     = (cnt_r <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + QUEUE_AW'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + QUEUE_AW'(pop);
  assign cnt_nxt    = cnt_r + (QUEUE_AW+1)'(push_cnt) - (QUEUE_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + QUEUE_AW'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/command_line_lexer_core.sv -----
// Command line lexer top level: byte requests in, lexeme and token-end requests out.
// The in_req channel takes one command line byte per request with a line_start
// flag that returns the lexer to idle before the byte is handled.
// The out_req channel delivers result items: lexeme characters and token ends
// with their token kind; last marks the final result caused by a byte.
// A byte is lexed in the cycle it is accepted and its results are written into a
// four-entry result queue, whose registered head drives out_req.
// Throughput: one byte per cycle while each byte gives at most one result and
// out_req.ready stays high; a byte that gives two results needs the result port
// for both, so the rate is set by the single result port, one result per cycle.
// in_req.ready is high while the queue has room for two results, so it drops
// when the receiver stalls and the queue fills, and bytes wait upstream.
// Reset (rst_n low at a clock edge) empties the queue and puts the lexer in idle.
`default_nettype none
module command_line_lexer_core (
  input  logic              clk,
  input  logic              rst_n,
  clx_in_if.sink            in_req,
  clx_out_if.source         out_req
);
  import clx_pkg::*;

  lex_state_t state_r;
  lex_state_t state_nxt;
  logic       accept;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  res_item_t  res0;
  res_item_t  res1;
  res_item_t  head;
  logic       room2;

  assign accept   = in_req.valid && in_req.ready;
  assign push_cnt = accept ? res_cnt : 2'd0;
  assign in_req.ready = room2;

  clx_step u_step (
    .state      (state_r),
    .char_code  (in_req.char_code),
    .line_start (in_req.line_start),
    .state_nxt  (state_nxt),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  clx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .out_valid (out_req.valid),
    .out_ready (out_req.ready),
    .out_item  (head)
  );

  assign out_req.item_kind  = head.item_kind;
  assign out_req.char_out   = head.char_out;
  assign out_req.token_kind = head.token_kind;
  assign out_req.last       = head.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- bench/command_line_lexer_core_tb.sv -----
// Self-checking bench for command_line_lexer_core: byte requests in, predicted results checked out.
module command_line_lexer_core_tb;
  import clx_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 20;

  logic clk;
  logic rst_n;

  clx_in_if  in_ch();
  clx_out_if out_ch();

  command_line_lexer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_req (out_ch)
  );

  lex_state_t lex_st;
  res_item_t  step_q[$];
  res_item_t  exp_q[$];

  int  in_idle_pct;
  int  out_idle_pct;
  int  cycle_cnt;
  int  errors;
  int  results_seen;
  int  bytes_sent;
  int  bytes_lexed;
  int  lines_sent;
  bit  start_pending;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_cnt, exp_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word_ch(input logic [7:0] c);
    return is_letter(c) || is_num(c) || c == CH_SLASH || c == CH_DOT || c == CH_UNDER;
  endfunction

  function automatic res_item_t mk_item(input logic kind, input logic [7:0] ch,
                                        input logic [1:0] tok);
    res_item_t r;
    r.item_kind  = kind;
    r.char_out   = ch;
    r.token_kind = tok;
    r.last       = 1'b0;
    return r;
  endfunction

  // One pass of the lexer over a byte; returns 1 when the byte must be lexed again from idle.
  function automatic bit lex_pass(input logic [7:0] c);
    bit again;
    again = 1'b0;
    case (lex_st)
      ST_IDLE: begin
        if (is_word_ch(c)) begin
          step_q.push_back(mk_item(ITEM_CHAR, c, TOK_NONE));
          lex_st = ST_WORD;
        end else if (c == CH_DASH) begin
          lex_st = ST_DASH;
        end else if (c == CH_TILDE) begin
          lex_st = ST_SEP;
        end else if (c == CH_QUOTE) begin
          lex_st = ST_QUOTE;
        end else if (c == CH_HASH) begin
          step_q.push_back(mk_item(ITEM_END, 8'd0, TOK_NONE));
          lex_st = ST_DONE;
        end
      end
      ST_DASH: begin
        if (is_letter(c)) begin
          step_q.push_back(mk_item(ITEM_CHAR, c, TOK_NONE));
          lex_st = ST_PNAME;
        end else if (is_num(c)) begin
          step_q.push_back(mk_item(ITEM_CHAR, CH_DASH, TOK_NONE));
          step_q.push_back(mk_item(ITEM_CHAR, c, TOK_NONE));
          lex_st = ST_NEG;
        end else begin
          step_q.push_back(mk_item(ITEM_END, 8'd0, TOK_NONE));
          lex_st = ST_IDLE;
          again = 1'b1;
        end
      end
      ST_WORD: begin
        if (is_word_ch(c)) begin
          step_q.push_back(mk_item(ITEM_CHAR, c, TOK_NONE));
        end else begin
          step_q.push_back(mk_item(ITEM_END, 8'd0, TOK_VALUE));
          lex_st = ST_IDLE;
          again = 1'b1;
        end
      end
      ST_QUOTE: begin
        if (c == CH_QUOTE) begin
          step_q.push_back(mk_item(ITEM_END, 8'd0, TOK_VALUE));
          lex_st = ST_IDLE;
        end else begin
          step_q.push_back(mk_item(ITEM_CHAR, c, TOK_NONE));
        end
      end
      ST_SEP: begin
        if (c != CH_TILDE && c != CH_COLON) begin
          step_q.push_back(mk_item(ITEM_END, 8'd0, TOK_SEP));
          lex_st = ST_IDLE;
          again = 1'b1;
        end
      end
      ST_NEG: begin
        if (is_num(c)) begin
          step_q.push_back(mk_item(ITEM_CHAR, c, TOK_NONE));
        end else begin
          step_q.push_back(mk_item(ITEM_END, 8'd0, TOK_VALUE));
          lex_st = ST_IDLE;
          again = 1'b1;
        end
      end
      ST_PNAME: begin
        if (is_letter(c) || is_num(c)) begin
          step_q.push_back(mk_item(ITEM_CHAR, c, TOK_NONE));
        end else begin
          step_q.push_back(mk_item(ITEM_END, 8'd0, TOK_PNAME));
          lex_st = ST_IDLE;
          again = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return again;
  endfunction

  task automatic predict_byte(input logic [7:0] c, input logic ls);
    step_q.delete();
    if (ls) lex_st = ST_IDLE;
    if (lex_pass(c)) void'(lex_pass(c));
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) exp_q.push_back(step_q[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    res_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected result, kind", out_ch.item_kind, 0);
      end else begin
        want = exp_q.pop_front();
        if (out_ch.item_kind !== want.item_kind)
          report_mismatch("item_kind", out_ch.item_kind, want.item_kind);
        if (out_ch.char_out !== want.char_out)
          report_mismatch("char_out", out_ch.char_out, want.char_out);
        if (out_ch.token_kind !== want.token_kind)
          report_mismatch("token_kind", out_ch.token_kind, want.token_kind);
        if (out_ch.last !== want.last)
          report_mismatch("last", out_ch.last, want.last);
      end
      results_seen++;
    end
  end

  task automatic send_byte(input logic [7:0] c, input logic ls);
    bit counted;
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_code  <= c;
    in_ch.line_start <= ls;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    counted = ls || (lex_st != ST_DONE);
    predict_byte(c, ls);
    if (counted) bytes_lexed++;
    bytes_sent++;
  endtask

  task automatic put(input logic [7:0] c);
    send_byte(c, start_pending);
    start_pending = 1'b0;
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? "A" + c : "a" + c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_word_ch();
    case ($urandom_range(0, 5))
      0: return CH_SLASH;
      1: return CH_DOT;
      2: return CH_UNDER;
      3: return pick_digit();
      default: return pick_letter();
    endcase
  endfunction

  task automatic send_token();
    logic [7:0] c;
    case ($urandom_range(0, 7))
      0: begin
        repeat ($urandom_range(1, 6)) put(pick_word_ch());
      end
      1: begin
        put(CH_DASH);
        put(pick_letter());
        repeat ($urandom_range(0, 4)) put($urandom_range(0, 1) ? pick_letter() : pick_digit());
      end
      2: begin
        put(CH_DASH);
        repeat ($urandom_range(1, 4)) put(pick_digit());
      end
      3: begin
        put(CH_TILDE);
        repeat ($urandom_range(0, 3)) put($urandom_range(0, 1) ? CH_TILDE : CH_COLON);
      end
      4: begin
        put(CH_QUOTE);
        repeat ($urandom_range(0, 5)) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_QUOTE) c = CH_HASH;
          put(c);
        end
        if ($urandom_range(0, 9) != 0) put(CH_QUOTE);
      end
      5: begin
        put(CH_DASH);
        put(8'($urandom_range(0, 255)));
      end
      6: put(8'($urandom_range(0, 255)));
      default: put(CH_COLON);
    endcase
  endtask

  task automatic send_line();
    start_pending = 1'b1;
    lines_sent++;
    repeat ($urandom_range(1, 6)) begin
      send_token();
      if ($urandom_range(0, 1)) put(" ");
    end
    if ($urandom_range(0, 9) != 0) begin
      put(CH_HASH);
      repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_words();
    start_pending = 1'b1;
    put("A");
    put("z");
    put("0");
    put("9");
    put(CH_SLASH);
    put(CH_DOT);
    put(CH_UNDER);
    put(" ");
  endtask

  task automatic test_dash_forms();
    put(CH_DASH);
    put("Z");
    put(CH_DASH);
    put("5");
    put(CH_DASH);
    put(CH_TILDE);
  endtask

  task automatic test_separators();
    put(CH_COLON);
    put("q");
    put(" ");
    put(CH_COLON);
  endtask

  task automatic test_quotes();
    put(CH_QUOTE);
    put(8'h00);
    put(CH_HASH);
    put(8'hFF);
    put(CH_QUOTE);
  endtask

  task automatic test_line_end();
    put(CH_HASH);
    put("a");
    start_pending = 1'b1;
    put(CH_QUOTE);
    put("b");
    start_pending = 1'b1;
    put(CH_HASH);
  endtask

  task automatic test_random_lines(input int n);
    int target;
    target = bytes_lexed + n;
    while (bytes_lexed < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        send_line();
      end
      if ($urandom_range(0, 19) == 0) hold_until_drained();
    end
  endtask

  initial begin
    cycle_cnt      = 0;
    errors         = 0;
    results_seen   = 0;
    bytes_sent     = 0;
    bytes_lexed    = 0;
    lines_sent     = 0;
    start_pending  = 1'b0;
    lex_st         = ST_IDLE;
    in_idle_pct    = 22;
    out_idle_pct   = 87;
    rst_n          = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = 8'd0;
    in_ch.line_start = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_words();
    test_dash_forms();
    test_separators();
    test_quotes();
    test_line_end();
    hold_until_drained();

    test_random_lines(170);
    in_idle_pct  = 87;
    out_idle_pct = 22;
    test_random_lines(170);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_lines(170);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (exp_q.size() != 0) report_mismatch("results left pending", exp_q.size(), 0);

    $display("covered %0d bytes (%0d lexed, %0d random lines), %0d results checked",
             bytes_sent, bytes_lexed, lines_sent, results_seen);
    $display("idle mixes: sender-light/receiver-heavy, reverse, and back-to-back");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
